// ----- rtl/core/pwbt_pkg.sv -----
// Package for the pulse-width bit transmitter: phase type, register codes,
// widths, reset values and the FIFO status struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pwbt_pkg;

  localparam int BYTE_W    = 8;
  localparam int ENTRY_W   = 9;   // data byte plus end-of-message mark
  localparam int END_BIT   = 8;
  localparam int BIDX_W    = 4;
  localparam int WAIT_W    = 9;
  localparam int CFG_IDX_W = 3;

  localparam logic [WAIT_W-1:0] WAIT_MAX = 9'd511;

  localparam logic [CFG_IDX_W-1:0] CFG_LEN_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_ZERO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_ONE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_STOP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_GAP  = 3'd4;

  localparam logic [BYTE_W-1:0] RST_LEN_START = 8'd8;
  localparam logic [BYTE_W-1:0] RST_LEN_ZERO  = 8'd1;
  localparam logic [BYTE_W-1:0] RST_LEN_ONE   = 8'd3;
  localparam logic [BYTE_W-1:0] RST_LEN_STOP  = 8'd8;
  localparam logic [BYTE_W-1:0] RST_IDLE_GAP  = 8'd10;

  typedef enum logic [2:0] {
    PH_START_HIGH = 3'd0,
    PH_START_LOW  = 3'd1,
    PH_MSG_HIGH   = 3'd2,
    PH_MSG_LOW    = 3'd3,
    PH_STOP_LOW   = 3'd4,
    PH_STOP_HIGH  = 3'd5,
    PH_IDLE       = 3'd6
  } phase_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/pwbt_in_if.sv -----
// Input channel: one tick or one byte push per transaction.
// Depends on pwbt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pwbt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [pwbt_pkg::BYTE_W-1:0]  data_byte;
  logic                         end_of_message;

  modport source (output valid, op, data_byte, end_of_message, input ready);
  modport sink   (input valid, op, data_byte, end_of_message, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pwbt_out_if.sv -----
// Result channel: line level, running flag and push-drop flag per transaction.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface pwbt_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic running;
  logic push_dropped;

  modport source (output valid, line_level, running, push_dropped, input ready);
  modport sink   (input valid, line_level, running, push_dropped, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pwbt_cfg_if.sv -----
// Configuration write channel: register index and write data.
// Depends on pwbt_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface pwbt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pwbt_pkg::CFG_IDX_W-1:0] index;
  logic [pwbt_pkg::BYTE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pwbt_fifo.sv -----
// Byte FIFO with a registered head word that always shows the oldest entry.
// Depends on pwbt_pkg for entry width and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module pwbt_fifo #(
  parameter int DEPTH = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire logic [pwbt_pkg::ENTRY_W-1:0]  push_data,
  input  wire logic                          pop,
  output pwbt_pkg::fifo_status_t             status,
  output logic      [pwbt_pkg::ENTRY_W-1:0]  head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [pwbt_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr, rd_ptr_next, wr_ptr_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic             do_push, do_pop;

  assign status.full  = (fill == CNT_W'(DEPTH));
  assign status.empty = (fill == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    fill_next   = fill;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_next = fill + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill   <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Head follows the next read pointer; bypass a write to that same slot.
  always_ff @(posedge clk) begin
    if (do_push && (wr_ptr == rd_ptr_next)) begin
      head <= push_data;
    end else begin
      head <= mem[rd_ptr_next];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pulse_width_bit_transmitter_unit.sv -----
// Pulse-width bit transmitter: one transaction per cycle while the result channel keeps up.
// Output: a result leaves the output register the cycle after its transaction.
// Throughput: one transaction per cycle unless a result waits unread, set by the single-pass
// phase update and the FIFO memory with one write and one registered head read per cycle.
// Reset (rst, synchronous): registers to defaults, line low, stopped, FIFO empty;
// FIFO contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module pulse_width_bit_transmitter_unit #(
  parameter int FIFO_DEPTH = 256
) (
  input wire logic   clk,
  input wire logic   rst,
  pwbt_in_if.sink    item,
  pwbt_out_if.source result,
  pwbt_cfg_if.sink   cfg
);

  // Configuration registers
  logic [pwbt_pkg::BYTE_W-1:0] len_start, len_zero, len_one, len_stop, idle_gap;

  // Transmitter state
  pwbt_pkg::phase_t              phase, phase_next;
  logic [pwbt_pkg::BYTE_W-1:0]   hold_count, hold_count_next;
  logic [pwbt_pkg::BIDX_W-1:0]   bit_index, bit_index_next;
  logic [pwbt_pkg::ENTRY_W-1:0]  current_byte, current_byte_next;
  logic                          cur_valid, cur_valid_next;
  logic [pwbt_pkg::WAIT_W-1:0]   messages_waiting, messages_waiting_next;
  logic                          run_flag, run_flag_next;
  logic                          line_reg, line_reg_next;

  // Result register
  logic out_valid;

  // FIFO interface
  pwbt_pkg::fifo_status_t       fifo_st;
  logic [pwbt_pkg::ENTRY_W-1:0] fifo_head;
  logic                         fifo_push, fifo_pop;

  // Decoded step controls
  logic accept, is_push, act, dropped;
  logic exhausted, end_or_empty;
  logic                          mh_valid;
  logic [pwbt_pkg::ENTRY_W-1:0]  mh_byte;
  logic [pwbt_pkg::BIDX_W-1:0]   mh_index;
  logic                          mh_bit;

  // Take a new transaction whenever the result register is free or draining.
  assign item.ready = !out_valid || result.ready;
  assign accept     = item.valid && item.ready;
  assign is_push    = accept && item.op;
  assign dropped    = is_push && fifo_st.full;
  assign fifo_push  = is_push && !fifo_st.full;

  // A tick acts on the phase only once the hold has run out.
  assign act = accept && !item.op && run_flag && (hold_count <= 8'd1);

  // Data-bit high phase: refill the byte once all eight bits have gone.
  assign exhausted    = cur_valid && bit_index[pwbt_pkg::BIDX_W-1];
  assign end_or_empty = current_byte[pwbt_pkg::END_BIT] || fifo_st.empty;
  assign mh_valid     = exhausted ? !end_or_empty : cur_valid;
  assign mh_byte      = exhausted ? (end_or_empty ? '0 : fifo_head) : current_byte;
  assign mh_index     = exhausted ? '0 : bit_index;
  assign mh_bit       = mh_byte[mh_index[pwbt_pkg::BIDX_W-2:0]];

  always_comb begin
    fifo_pop = 1'b0;
    if (act) begin
      case (phase)
        pwbt_pkg::PH_START_LOW:
          fifo_pop = (messages_waiting != '0) && !fifo_st.empty;
        pwbt_pkg::PH_MSG_HIGH:
          fifo_pop = exhausted && !end_or_empty;
        default:
          fifo_pop = 1'b0;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (act) begin
      case (phase)
        pwbt_pkg::PH_START_HIGH: phase_next = pwbt_pkg::PH_START_LOW;
        pwbt_pkg::PH_START_LOW:  phase_next = pwbt_pkg::PH_MSG_HIGH;
        pwbt_pkg::PH_MSG_HIGH:
          phase_next = mh_valid ? pwbt_pkg::PH_MSG_LOW : pwbt_pkg::PH_STOP_LOW;
        pwbt_pkg::PH_MSG_LOW:    phase_next = pwbt_pkg::PH_MSG_HIGH;
        pwbt_pkg::PH_STOP_LOW:   phase_next = pwbt_pkg::PH_STOP_HIGH;
        pwbt_pkg::PH_STOP_HIGH:  phase_next = pwbt_pkg::PH_IDLE;
        default:
          phase_next = (messages_waiting == '0) ? pwbt_pkg::PH_IDLE
                                                : pwbt_pkg::PH_START_HIGH;
      endcase
    end
  end

  // Counters, byte register, line and run flag
  always_comb begin
    hold_count_next       = hold_count;
    bit_index_next        = bit_index;
    current_byte_next     = current_byte;
    cur_valid_next        = cur_valid;
    messages_waiting_next = messages_waiting;
    run_flag_next         = run_flag;
    line_reg_next         = line_reg;

    if (fifo_push && item.end_of_message) begin
      if (messages_waiting < pwbt_pkg::WAIT_MAX) begin
        messages_waiting_next = messages_waiting + 1'b1;
      end
      run_flag_next = 1'b1;
    end

    if (accept && !item.op && run_flag && (hold_count > 8'd1)) begin
      hold_count_next = hold_count - 1'b1;
    end

    if (act) begin
      case (phase)
        pwbt_pkg::PH_START_HIGH: begin
          line_reg_next   = 1'b1;
          hold_count_next = len_start;
        end
        pwbt_pkg::PH_START_LOW: begin
          line_reg_next     = 1'b0;
          hold_count_next   = len_start;
          bit_index_next    = '0;
          cur_valid_next    = 1'b0;
          current_byte_next = '0;
          if (messages_waiting != '0) begin
            messages_waiting_next = messages_waiting - 1'b1;
            if (!fifo_st.empty) begin
              current_byte_next = fifo_head;
              cur_valid_next    = 1'b1;
            end
          end
        end
        pwbt_pkg::PH_MSG_HIGH: begin
          cur_valid_next    = mh_valid;
          current_byte_next = mh_byte;
          bit_index_next    = mh_index;
          if (!mh_valid) begin
            line_reg_next = 1'b0;
          end else begin
            line_reg_next   = 1'b1;
            hold_count_next = mh_bit ? len_one : len_zero;
            bit_index_next  = mh_index + 1'b1;
          end
        end
        pwbt_pkg::PH_MSG_LOW: begin
          line_reg_next = 1'b0;
        end
        pwbt_pkg::PH_STOP_LOW: begin
          line_reg_next   = 1'b0;
          hold_count_next = len_stop;
        end
        pwbt_pkg::PH_STOP_HIGH: begin
          line_reg_next   = 1'b1;
          hold_count_next = len_stop;
        end
        default: begin
          // Idle: stop, or wait out the gap before the next start frame.
          line_reg_next = 1'b0;
          if (messages_waiting == '0) begin
            run_flag_next = 1'b0;
          end else begin
            hold_count_next = idle_gap;
            bit_index_next  = '0;
          end
        end
      endcase
    end
  end

  // Hold state between transactions; advance only on an accepted one.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= pwbt_pkg::PH_START_HIGH;
      hold_count       <= 8'd1;
      bit_index        <= '0;
      current_byte     <= '0;
      cur_valid        <= 1'b0;
      messages_waiting <= '0;
      run_flag         <= 1'b0;
      line_reg         <= 1'b0;
    end else begin
      phase            <= phase_next;
      hold_count       <= hold_count_next;
      bit_index        <= bit_index_next;
      current_byte     <= current_byte_next;
      cur_valid        <= cur_valid_next;
      messages_waiting <= messages_waiting_next;
      run_flag         <= run_flag_next;
      line_reg         <= line_reg_next;
    end
  end

  // Result register: load on accept, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.line_level   <= line_reg_next;
      result.running      <= run_flag_next;
      result.push_dropped <= dropped;
    end
  end

  assign result.valid = out_valid;

  // Configuration writes are always taken; unknown indexes are ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_start <= pwbt_pkg::RST_LEN_START;
      len_zero  <= pwbt_pkg::RST_LEN_ZERO;
      len_one   <= pwbt_pkg::RST_LEN_ONE;
      len_stop  <= pwbt_pkg::RST_LEN_STOP;
      idle_gap  <= pwbt_pkg::RST_IDLE_GAP;
    end else if (cfg.valid) begin
      case (cfg.index)
        pwbt_pkg::CFG_LEN_START: len_start <= cfg.data;
        pwbt_pkg::CFG_LEN_ZERO:  len_zero  <= cfg.data;
        pwbt_pkg::CFG_LEN_ONE:   len_one   <= cfg.data;
        pwbt_pkg::CFG_LEN_STOP:  len_stop  <= cfg.data;
        pwbt_pkg::CFG_IDLE_GAP:  idle_gap  <= cfg.data;
        default: ;
      endcase
    end
  end

  pwbt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_data ({item.end_of_message, item.data_byte}),
    .pop       (fifo_pop),
    .status    (fifo_st),
    .head      (fifo_head)
  );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for pulse_width_bit_transmitter_unit: directed table, FIFO flood,
// then randomised traffic over several length settings, checked against a cycle-free predictor.
// Depends on pwbt_pkg and the three channel interfaces from the RTL tree.
`timescale 1ns / 1ps

module testbench;

  localparam int FIFO_DEPTH = 256;
  localparam int TIMEOUT_NS = 2_000_000;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 8;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DIR_ROWS = 24;

  // Input operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  typedef logic [pwbt_pkg::BYTE_W-1:0]    byte_t;
  typedef logic [pwbt_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  typedef struct packed {
    logic line_level;
    logic running;
    logic push_dropped;
  } line_state_t;

  // One row of the directed table; typed marks rows whose result is written in by hand
  typedef struct packed {
    logic        op;
    byte_t       data_byte;
    logic        end_of_message;
    logic        typed;
    line_state_t result;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{OP_TICK, 8'h00, 1'b0, 1'b1, 3'b000},  // tick while stopped: nothing moves
    '{OP_PUSH, 8'h00, 1'b0, 1'b1, 3'b000},  // queued, message not yet complete
    '{OP_PUSH, 8'hFF, 1'b1, 1'b1, 3'b010},  // last byte: transmitter starts
    '{OP_TICK, 8'h00, 1'b0, 1'b1, 3'b110},  // start frame rises on the first tick
    '{OP_PUSH, 8'h80, 1'b1, 1'b1, 3'b110},  // push mid-frame leaves the line alone
    '{OP_TICK, 8'hFF, 1'b1, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 1'b0, 3'b000},
    '{OP_PUSH, 8'h01, 1'b0, 1'b0, 3'b000},
    '{OP_PUSH, 8'h7F, 1'b1, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 1'b0, 3'b000},
    '{OP_TICK, 8'h00, 1'b0, 1'b0, 3'b000}
  };

  logic clk;
  logic rst;

  pwbt_in_if  item_ch ();
  pwbt_out_if result_ch ();
  pwbt_cfg_if cfg_ch ();

  pulse_width_bit_transmitter_unit #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the transmitter, advanced once per
  // accepted input transaction.
  // ---------------------------------------------------------------------------
  byte_t                          len_start, len_zero, len_one, len_stop, idle_gap;
  pwbt_pkg::phase_t               ph;
  byte_t                          hold;
  logic [pwbt_pkg::BIDX_W-1:0]    bit_idx;
  logic [pwbt_pkg::ENTRY_W-1:0]   cur_entry;
  logic                           cur_valid;
  logic [pwbt_pkg::ENTRY_W-1:0]   fifo_mem [FIFO_DEPTH];
  int unsigned                    rd_ptr, wr_ptr, fill;
  logic [pwbt_pkg::WAIT_W-1:0]    msgs_waiting;
  logic                           run_flag;
  logic                           line_reg;

  // Line states predicted but not yet seen on the result channel, oldest first
  line_state_t pending_line_states [$];

  int fail_count;
  int tx_idle_pct;
  int rx_idle_pct;
  bit rx_hold_req;

  function automatic void queue_expected(input line_state_t s);
    pending_line_states.insert(pending_line_states.size(), s);
  endfunction

  function automatic line_state_t take_expected();
    line_state_t s;
    s = pending_line_states[0];
    pending_line_states.delete(0);
    return s;
  endfunction

  function automatic void reset_transmitter_copy();
    len_start    = pwbt_pkg::RST_LEN_START;
    len_zero     = pwbt_pkg::RST_LEN_ZERO;
    len_one      = pwbt_pkg::RST_LEN_ONE;
    len_stop     = pwbt_pkg::RST_LEN_STOP;
    idle_gap     = pwbt_pkg::RST_IDLE_GAP;
    ph           = pwbt_pkg::PH_START_HIGH;
    hold         = 8'd1;
    bit_idx      = '0;
    cur_entry    = '0;
    cur_valid    = 1'b0;
    rd_ptr       = 0;
    wr_ptr       = 0;
    fill         = 0;
    msgs_waiting = '0;
    run_flag     = 1'b0;
    line_reg     = 1'b0;
  endfunction

  function automatic logic [pwbt_pkg::ENTRY_W-1:0] pop_entry();
    logic [pwbt_pkg::ENTRY_W-1:0] e;
    e      = fifo_mem[rd_ptr];
    rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
    fill   = fill - 1;
    return e;
  endfunction

  // One timer tick: count down the hold, or perform the action of the phase
  function automatic void advance_tick();
    if (hold > 8'd1) begin
      hold = hold - 8'd1;
    end else begin
      case (ph)
        pwbt_pkg::PH_START_HIGH: begin
          line_reg = 1'b1;
          hold     = len_start;
          ph       = pwbt_pkg::PH_START_LOW;
        end
        pwbt_pkg::PH_START_LOW: begin
          line_reg  = 1'b0;
          hold      = len_start;
          ph        = pwbt_pkg::PH_MSG_HIGH;
          bit_idx   = '0;
          cur_valid = 1'b0;
          cur_entry = '0;
          if (msgs_waiting != '0) begin
            msgs_waiting = msgs_waiting - 1'b1;
            if (fill > 0) begin
              cur_entry = pop_entry();
              cur_valid = 1'b1;
            end
          end
        end
        pwbt_pkg::PH_MSG_HIGH: begin
          // Byte used up: close the message on its end mark or an empty FIFO
          if (cur_valid && bit_idx > 4'd7) begin
            if (cur_entry[pwbt_pkg::END_BIT] || fill == 0) begin
              cur_valid = 1'b0;
              cur_entry = '0;
            end else begin
              cur_entry = pop_entry();
            end
            bit_idx = '0;
          end
          if (!cur_valid) begin
            line_reg = 1'b0;
            ph       = pwbt_pkg::PH_STOP_LOW;
          end else begin
            line_reg = 1'b1;
            hold     = cur_entry[bit_idx[2:0]] ? len_one : len_zero;
            bit_idx  = bit_idx + 1'b1;
            ph       = pwbt_pkg::PH_MSG_LOW;
          end
        end
        pwbt_pkg::PH_MSG_LOW: begin
          line_reg = 1'b0;
          ph       = pwbt_pkg::PH_MSG_HIGH;
        end
        pwbt_pkg::PH_STOP_LOW: begin
          line_reg = 1'b0;
          hold     = len_stop;
          ph       = pwbt_pkg::PH_STOP_HIGH;
        end
        pwbt_pkg::PH_STOP_HIGH: begin
          line_reg = 1'b1;
          hold     = len_stop;
          ph       = pwbt_pkg::PH_IDLE;
        end
        default: begin
          line_reg = 1'b0;
          ph       = pwbt_pkg::PH_IDLE;
          if (msgs_waiting == '0) begin
            run_flag = 1'b0;
          end else begin
            hold    = idle_gap;
            bit_idx = '0;
            ph      = pwbt_pkg::PH_START_HIGH;
          end
        end
      endcase
    end
  endfunction

  function automatic line_state_t predict_line_state(input logic op,
                                                     input byte_t data,
                                                     input logic eom);
    line_state_t r;
    r.push_dropped = 1'b0;
    if (op == OP_PUSH) begin
      if (fill >= FIFO_DEPTH) begin
        // Full: the byte and its end mark are both lost
        r.push_dropped = 1'b1;
      end else begin
        fifo_mem[wr_ptr] = {eom, data};
        wr_ptr           = (wr_ptr + 1) % FIFO_DEPTH;
        fill             = fill + 1;
        if (eom) begin
          if (msgs_waiting < pwbt_pkg::WAIT_MAX) msgs_waiting = msgs_waiting + 1'b1;
          run_flag = 1'b1;
        end
      end
    end else if (run_flag) begin
      advance_tick();
    end
    r.line_level = line_reg;
    r.running    = run_flag;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run well beyond the slowest legal schedule
  initial begin
    #(TIMEOUT_NS);
    $display("pulse_width_bit_transmitter_unit regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one input transaction; hold valid high afterwards so that a following
  // transaction can go out back to back. Predict its line state on acceptance.
  task automatic send_item(input logic op, input byte_t data,
                           input logic eom, input logic typed = 1'b0,
                           input line_state_t typed_res = '0);
    line_state_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.op             <= op;
    item_ch.data_byte      <= data;
    item_ch.end_of_message <= eom;
    do @(posedge clk); while (!item_ch.ready);
    predicted = predict_line_state(op, data, eom);
    queue_expected(typed ? typed_res : predicted);
  endtask

  // Drop valid and wait until every predicted line state has been seen
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    while (pending_line_states.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg valid high; the caller drops it after the last write
  task automatic write_reg(input cfg_idx_t idx, input byte_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      pwbt_pkg::CFG_LEN_START: len_start = value;
      pwbt_pkg::CFG_LEN_ZERO:  len_zero  = value;
      pwbt_pkg::CFG_LEN_ONE:   len_one   = value;
      pwbt_pkg::CFG_LEN_STOP:  len_stop  = value;
      pwbt_pkg::CFG_IDLE_GAP:  idle_gap  = value;
      default: ;
    endcase
  endtask

  task automatic program_lengths(input byte_t s, input byte_t z, input byte_t o,
                                 input byte_t p, input byte_t g);
    write_reg(pwbt_pkg::CFG_LEN_START, s);
    write_reg(pwbt_pkg::CFG_LEN_ZERO, z);
    write_reg(pwbt_pkg::CFG_LEN_ONE, o);
    write_reg(pwbt_pkg::CFG_LEN_STOP, p);
    write_reg(pwbt_pkg::CFG_IDLE_GAP, g);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly complete messages and bursts of ticks, with some stray pushes
  task automatic run_traffic(input int n_items);
    int sent;
    int pick;
    int n_bytes;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        n_bytes = $urandom_range(1, 3);
        for (int b = 0; b < n_bytes; b++)
          send_item(OP_PUSH, byte_t'($urandom_range(0, 255)), b == n_bytes - 1);
        sent += n_bytes;
      end else if (pick < 22) begin
        send_item(OP_PUSH, byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        burst = $urandom_range(1, 40);
        repeat (burst)
          send_item(OP_TICK, byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sent += burst;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: check each result transaction, drive ready
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    line_state_t want;
    int          hold_left;
    int          reports;
    hold_left       = 0;
    reports         = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        if (pending_line_states.size() == 0) begin
          fail_count++;
          if (reports < MAX_REPORTS)
            $display("[%0t] unexpected result: line=%b running=%b dropped=%b", $realtime,
                     result_ch.line_level, result_ch.running, result_ch.push_dropped);
          reports++;
        end else begin
          want = take_expected();
          if (result_ch.line_level !== want.line_level || result_ch.running !== want.running ||
              result_ch.push_dropped !== want.push_dropped) begin
            fail_count++;
            if (reports < MAX_REPORTS)
              $display("[%0t] mismatch: line %b/%b running %b/%b dropped %b/%b (exp/act)",
                       $realtime, want.line_level, result_ch.line_level, want.running,
                       result_ch.running, want.push_dropped, result_ch.push_dropped);
            reports++;
          end
        end
      end
      // Long hold-off on request, otherwise stall at the current rate
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = RX_HOLD_CYCLES;
      end
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst                    = 1'b1;
    item_ch.valid          = 1'b0;
    item_ch.op             = OP_TICK;
    item_ch.data_byte      = '0;
    item_ch.end_of_message = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = pwbt_pkg::CFG_LEN_START;
    cfg_ch.data            = '0;
    fail_count             = 0;
    // Sender idles rarely, receiver often
    tx_idle_pct            = 8;
    rx_idle_pct            = 69;
    rx_hold_req            = 1'b0;
    reset_transmitter_copy();

    // Hold reset, then release it for good
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed table at reset lengths
    foreach (DIRECTED_ROWS[i])
      send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].data_byte,
                DIRECTED_ROWS[i].end_of_message, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].result);
    drain_results();

    // Flood the FIFO to full, closing it with an end mark so that it can
    // drain later, then push a few more that must be dropped
    while (fill < FIFO_DEPTH)
      send_item(OP_PUSH, byte_t'($urandom_range(0, 255)),
                (fill == FIFO_DEPTH - 1) || ($urandom_range(0, 3) == 0));
    repeat (4)
      send_item(OP_PUSH, byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'b1, 3'b011);
    drain_results();

    program_lengths(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    run_traffic(60);
    drain_results();

    // Zero lengths behave as one; writes to unused indexes must be ignored
    for (int idx = pwbt_pkg::CFG_IDLE_GAP + 1; idx < (1 << pwbt_pkg::CFG_IDX_W); idx++)
      write_reg(cfg_idx_t'(idx), byte_t'($urandom_range(0, 255)));
    program_lengths(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_traffic(60);
    drain_results();

    // Swap the idling rates
    tx_idle_pct = 69;
    rx_idle_pct = 8;
    program_lengths(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    run_traffic(30);
    drain_results();

    program_lengths(byte_t'($urandom_range(1, 8)), byte_t'($urandom_range(1, 8)),
                    byte_t'($urandom_range(1, 8)), byte_t'($urandom_range(1, 8)),
                    byte_t'($urandom_range(1, 8)));
    run_traffic(60);
    drain_results();

    // No idling; stall the receiver for a long stretch so the input backs up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_lengths(byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
                    byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
                    byte_t'($urandom_range(0, 255)));
    rx_hold_req = 1'b1;
    run_traffic(50);
    // Pause the sender until every result is back, then carry on
    drain_results();
    run_traffic(50);
    drain_results();

    program_lengths(pwbt_pkg::RST_LEN_START, pwbt_pkg::RST_LEN_ZERO, pwbt_pkg::RST_LEN_ONE,
                    pwbt_pkg::RST_LEN_STOP, pwbt_pkg::RST_IDLE_GAP);
    run_traffic(50);
    drain_results();

    // Allow for the output latency before judging
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("pulse_width_bit_transmitter_unit regression: pass");
    end else begin
      $display("pulse_width_bit_transmitter_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/pwbt_pkg.sv
rtl/core/pwbt_in_if.sv
rtl/core/pwbt_out_if.sv
rtl/core/pwbt_cfg_if.sv
rtl/core/pwbt_fifo.sv
rtl/core/pulse_width_bit_transmitter_unit.sv
dv/testbench.sv
